// ===== rtl/core/arpr_pkg.sv =====
// Shared types and constants for the ARP responder with peer learning.
`default_nettype none
package arpr_pkg;

    localparam int FRAME_MAX_DEF = 64;   // default frame buffer depth in bytes
    localparam int ARP_LEN       = 42;   // Ethernet header plus ARP body
    localparam int JOBQ_DEPTH    = 2;    // jobs between classifier and transmitter
    localparam int OUT_DEPTH     = 4;    // result words buffered at the output

    typedef enum logic [1:0] {
        OP_WHO_HAS,
        OP_STATUS,
        OP_REPLY
    } t_op;

    typedef struct packed {
        logic [31:0] own_ip;
        logic [31:0] peer_ip;
        logic [47:0] own_mac;
    } t_cfg;

    // mac_a: Ethernet source for a reply, learned MAC for a status job
    // mac_b: sender MAC of the request
    // ip   : target IP of a who-has, sender IP of a reply
    // flag : learned mark for a status job
    typedef struct packed {
        t_op         op;
        logic [47:0] mac_a;
        logic [47:0] mac_b;
        logic [31:0] ip;
        logic        flag;
    } t_job;

endpackage
`default_nettype wire

// ===== rtl/core/arpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module arpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/arpr_jobq.sv =====
// Short job queue between the frame classifier and the transmitter.
`default_nettype none
module arpr_jobq #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic      [W-1:0] o_data
);

    localparam int PW = (arpr_pkg::JOBQ_DEPTH > 1) ? $clog2(arpr_pkg::JOBQ_DEPTH) : 1;
    localparam int CNTW = $clog2(arpr_pkg::JOBQ_DEPTH + 1);

    logic [W-1:0]    r_mem [arpr_pkg::JOBQ_DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CNTW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CNTW'(arpr_pkg::JOBQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
        return (p == PW'(arpr_pkg::JOBQ_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= inc(r_rptr);
            end
            r_cnt <= r_cnt + CNTW'(do_push) - CNTW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(arpr_pkg::JOBQ_DEPTH))
        else $error("job queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/core/arpr_front.sv =====
// Front end: accepts words, stores frame bytes, checks ARP headers, learns the peer, queues jobs.
`default_nettype none
module arpr_front #(
    parameter int FRAME_MAX = arpr_pkg::FRAME_MAX_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_frame_end,
    input  wire arpr_pkg::t_cfg                i_cfg,
    output logic                               o_ram_we,
    output logic [$clog2(FRAME_MAX)-1:0]       o_ram_waddr,
    output logic [7:0]                         o_ram_wdata,
    output logic                               o_job_push,
    output arpr_pkg::t_job                     o_job,
    output logic [$clog2(FRAME_MAX+1)-1:0]     o_job_len,
    input  wire logic                          i_job_full,
    input  wire logic                          i_reply_done
);

    localparam int CW = $clog2(FRAME_MAX + 1);
    localparam int AW = $clog2(FRAME_MAX);

    localparam logic [1:0] CMD_BYTE     = 2'd0;
    localparam logic [1:0] CMD_WHO_PEER = 2'd1;
    localparam logic [1:0] CMD_ANNOUNCE = 2'd2;
    localparam logic [1:0] CMD_STATUS   = 2'd3;

    logic [CW-1:0] r_count, n_len;
    logic          r_ovf, n_ovf;
    logic          r_reply_busy;
    logic [47:0]   r_learn_mac;
    logic          r_learn_valid;

    // header fields shifted in as their bytes go by
    logic [47:0] r_esrc, n_esrc, r_sha, n_sha;
    logic [31:0] r_hwpr, n_hwpr, r_sip, n_sip, r_tip, n_tip;
    logic [15:0] r_op, n_op;

    logic acc, byte_acc, store, fin, frame_ok, learn, reply;

    function automatic logic in_win(logic [CW-1:0] c, int lo, int hi);
        return (c >= CW'(lo)) && (c <= CW'(hi));
    endfunction

    assign o_full   = i_job_full || r_reply_busy;
    assign acc      = i_push && !o_full;
    assign byte_acc = acc && (i_cmd == CMD_BYTE);
    assign store    = byte_acc && (r_count < CW'(FRAME_MAX));
    assign fin      = byte_acc && i_frame_end;

    assign o_ram_we    = store;
    assign o_ram_waddr = r_count[AW-1:0];
    assign o_ram_wdata = i_data_byte;

    always_comb begin
        n_esrc = r_esrc;
        n_hwpr = r_hwpr;
        n_op   = r_op;
        n_sha  = r_sha;
        n_sip  = r_sip;
        n_tip  = r_tip;
        if (store) begin
            if (in_win(r_count, 6, 11))  n_esrc = {r_esrc[39:0], i_data_byte};
            if (in_win(r_count, 14, 17)) n_hwpr = {r_hwpr[23:0], i_data_byte};
            if (in_win(r_count, 20, 21)) n_op   = {r_op[7:0], i_data_byte};
            if (in_win(r_count, 22, 27)) n_sha  = {r_sha[39:0], i_data_byte};
            if (in_win(r_count, 28, 31)) n_sip  = {r_sip[23:0], i_data_byte};
            if (in_win(r_count, 38, 41)) n_tip  = {r_tip[23:0], i_data_byte};
        end
    end

    assign n_len = store ? r_count + CW'(1) : r_count;
    assign n_ovf = r_ovf || (byte_acc && !store);

    // hardware type 1 and protocol 0x0800
    assign frame_ok = fin && !n_ovf && (n_len >= CW'(arpr_pkg::ARP_LEN))
                      && (n_hwpr == 32'h0001_0800);
    assign learn    = frame_ok && (n_sip == i_cfg.peer_ip);
    assign reply    = frame_ok && (n_op == 16'h0001) && (n_tip == i_cfg.own_ip);

    assign o_job_push = (acc && (i_cmd != CMD_BYTE)) || reply;

    always_comb begin
        o_job       = '0;
        o_job_len   = CW'(arpr_pkg::ARP_LEN);
        o_job.op    = arpr_pkg::OP_WHO_HAS;
        unique case (i_cmd)
            CMD_WHO_PEER: begin
                o_job.ip = i_cfg.peer_ip;
            end
            CMD_ANNOUNCE: begin
                o_job.ip = i_cfg.own_ip;
            end
            CMD_STATUS: begin
                o_job.op    = arpr_pkg::OP_STATUS;
                o_job.mac_a = r_learn_mac;
                o_job.flag  = r_learn_valid;
                o_job_len   = CW'(1);
            end
            default: begin
                o_job.op    = arpr_pkg::OP_REPLY;
                o_job.mac_a = n_esrc;
                o_job.mac_b = n_sha;
                o_job.ip    = n_sip;
                o_job_len   = n_len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_ovf         <= 1'b0;
            r_reply_busy  <= 1'b0;
            r_learn_mac   <= '0;
            r_learn_valid <= 1'b0;
        end else begin
            if (fin) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_len;
                r_ovf   <= n_ovf;
            end
            if (learn) begin
                r_learn_mac   <= n_sha;
                r_learn_valid <= 1'b1;
            end
            // frame store is read back by the transmitter until the reply is out
            if (reply) begin
                r_reply_busy <= 1'b1;
            end else if (i_reply_done) begin
                r_reply_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_esrc <= n_esrc;
        r_hwpr <= n_hwpr;
        r_op   <= n_op;
        r_sha  <= n_sha;
        r_sip  <= n_sip;
        r_tip  <= n_tip;
    end

    a_no_write_in_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reply_busy |-> !o_ram_we)
        else $error("frame store written while a reply reads it");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FRAME_MAX))
        else $error("byte count past buffer depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> !i_job_full)
        else $error("job pushed into full queue");

endmodule
`default_nettype wire

// ===== rtl/core/arpr_back.sv =====
// Back end: runs queued jobs, builds outgoing bytes and status words into an output queue.
`default_nettype none
module arpr_back #(
    parameter int FRAME_MAX = arpr_pkg::FRAME_MAX_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire arpr_pkg::t_cfg                i_cfg,
    input  wire logic                          i_job_empty,
    input  wire arpr_pkg::t_job                i_job,
    input  wire logic [$clog2(FRAME_MAX+1)-1:0] i_job_len,
    output logic                               o_job_pop,
    output logic [$clog2(FRAME_MAX)-1:0]       o_ram_raddr,
    input  wire logic [7:0]                    i_ram_rdata,
    output logic                               o_reply_done,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic                               o_kind,
    output logic [7:0]                         o_tx_byte,
    output logic                               o_tx_last,
    output logic [47:0]                        o_peer_mac,
    output logic                               o_peer_mac_valid
);

    localparam int CW   = $clog2(FRAME_MAX + 1);
    localparam int AW   = $clog2(FRAME_MAX);
    localparam int PW   = $clog2(arpr_pkg::OUT_DEPTH);
    localparam int CNTW = $clog2(arpr_pkg::OUT_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [47:0] peer_mac;
        logic        peer_mac_valid;
    } t_out;

    logic           r_busy;
    arpr_pkg::t_job r_job;
    logic [CW-1:0]  r_len, r_k;

    logic           r_b_valid, r_b_use_ram;
    t_out           r_b_word;

    t_out            r_oq [arpr_pkg::OUT_DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CNTW-1:0] r_cnt;

    logic     room, issue, last, hdr, use_ram, oq_pop;
    logic [5:0] p;
    logic [8:0] rsel;
    t_out     word, b_out;

    function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [5:0] off);
        logic [7:0] b;
        unique case (off[2:0])
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(logic [31:0] ip, logic [5:0] off);
        logic [7:0] b;
        unique case (off[1:0])
            2'd0:    b = ip[31:24];
            2'd1:    b = ip[23:16];
            2'd2:    b = ip[15:8];
            default: b = ip[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] whohas_byte(logic [5:0] q, logic [47:0] mac,
                                               logic [31:0] sip, logic [31:0] tip);
        logic [7:0] b;
        b = 8'h00;
        if (q <= 6'd5)       b = 8'hFF;
        else if (q <= 6'd11) b = mac_byte(mac, q - 6'd6);
        else if (q <= 6'd21) begin
            unique case (q)
                6'd12:   b = 8'h08;
                6'd13:   b = 8'h06;
                6'd16:   b = 8'h08;
                6'd18:   b = 8'h06;
                6'd19:   b = 8'h04;
                6'd15,
                6'd21:   b = 8'h01;
                default: b = 8'h00;
            endcase
        end
        else if (q <= 6'd27) b = mac_byte(mac, q - 6'd22);
        else if (q <= 6'd31) b = ip_byte(sip, q - 6'd28);
        else if (q <= 6'd37) b = 8'h00;
        else                 b = ip_byte(tip, q - 6'd38);
        return b;
    endfunction

    // {take from frame store, byte}
    function automatic logic [8:0] reply_byte(logic [5:0] q, arpr_pkg::t_job j,
                                              arpr_pkg::t_cfg c);
        logic [8:0] r;
        r = {1'b1, 8'h00};
        if (q <= 6'd5)                       r = {1'b0, mac_byte(j.mac_a, q)};
        else if (q <= 6'd11)                 r = {1'b0, mac_byte(c.own_mac, q - 6'd6)};
        else if (q == 6'd21)                 r = {1'b0, 8'h02};
        else if (q >= 6'd22 && q <= 6'd27)   r = {1'b0, mac_byte(c.own_mac, q - 6'd22)};
        else if (q >= 6'd28 && q <= 6'd31)   r = {1'b0, ip_byte(c.own_ip, q - 6'd28)};
        else if (q >= 6'd32 && q <= 6'd37)   r = {1'b0, mac_byte(j.mac_b, q - 6'd32)};
        else if (q >= 6'd38 && q <= 6'd41)   r = {1'b0, ip_byte(j.ip, q - 6'd38)};
        return r;
    endfunction

    // a word is issued only when the output queue has a slot for it in the following cycle
    assign room      = (r_cnt + CNTW'(r_b_valid)) < CNTW'(arpr_pkg::OUT_DEPTH);
    assign issue     = r_busy && room;
    assign last      = (r_k == r_len - CW'(1));
    assign o_job_pop = !r_busy && !i_job_empty;
    assign o_ram_raddr  = r_k[AW-1:0];
    assign o_reply_done = issue && last && (r_job.op == arpr_pkg::OP_REPLY);

    assign hdr  = (r_k < CW'(arpr_pkg::ARP_LEN));
    assign p    = r_k[5:0];
    assign rsel = reply_byte(p, r_job, i_cfg);

    always_comb begin
        word    = '0;
        use_ram = 1'b0;
        word.tx_last = last;
        unique case (r_job.op)
            arpr_pkg::OP_STATUS: begin
                word.kind           = 1'b1;
                word.tx_last        = 1'b1;
                word.peer_mac       = r_job.mac_a;
                word.peer_mac_valid = r_job.flag;
            end
            arpr_pkg::OP_WHO_HAS: begin
                word.tx_byte = whohas_byte(p, i_cfg.own_mac, i_cfg.own_ip, r_job.ip);
            end
            default: begin
                use_ram      = !hdr || rsel[8];
                word.tx_byte = rsel[7:0];
            end
        endcase
    end

    always_comb begin
        b_out = r_b_word;
        if (r_b_use_ram) begin
            b_out.tx_byte = i_ram_rdata;
        end
    end

    assign oq_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_b_valid <= 1'b0;
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_cnt     <= '0;
        end else begin
            if (o_job_pop) begin
                r_busy <= 1'b1;
            end else if (issue && last) begin
                r_busy <= 1'b0;
            end
            r_b_valid <= issue;
            if (r_b_valid) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (oq_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_cnt <= r_cnt + CNTW'(r_b_valid) - CNTW'(oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
            r_len <= i_job_len;
            r_k   <= '0;
        end else if (issue) begin
            r_k <= r_k + CW'(1);
        end
        r_b_word    <= word;
        r_b_use_ram <= use_ram;
        if (r_b_valid) begin
            r_oq[r_wptr] <= b_out;
        end
    end

    assign o_empty          = (r_cnt == '0);
    assign o_kind           = r_oq[r_rptr].kind;
    assign o_tx_byte        = r_oq[r_rptr].tx_byte;
    assign o_tx_last        = r_oq[r_rptr].tx_last;
    assign o_peer_mac       = r_oq[r_rptr].peer_mac;
    assign o_peer_mac_valid = r_oq[r_rptr].peer_mac_valid;

    a_oq_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_cnt < CNTW'(arpr_pkg::OUT_DEPTH)))
        else $error("output queue overrun");

    a_job_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && last) |=> !r_busy)
        else $error("job still running after its last word");

endmodule
`default_nettype wire

// ===== rtl/core/arp_responder_with_peer_learning_core.sv =====
// ARP responder with upstream peer learning: top level with configuration registers.
//
// Input queue (push/full): cmd 0 carries one received frame byte, frame_end
// marks the last one; cmd 1 sends a who-has for peer_ip, cmd 2 a gratuitous
// announcement, cmd 3 reads the learned peer MAC. Frame bytes are taken one
// per cycle unless full. A request for own_ip is answered at the received length.
// Result queue (empty/pop): transmitted bytes (kind 0) with tx_last on the
// final byte, or one status word (kind 1).
// A job goes from the job queue to the transmitter's job register; each word
// goes through a staging register, with the registered frame store read, into
// the 4-deep output queue: one byte per cycle while that queue has room.
// A job queue of two sits between the classifier and the transmitter; full
// rises when it is full, and while a reply is still being read out of the
// frame store (until its last byte is issued), so after the last byte of an
// answered request full stays high until the reply's last byte is issued.
// When the result side stalls, the output queue fills, the transmitter
// waits, then the job queue fills and full rises.
// Reset clears registers, counters, the learned MAC and all queues; the frame
// store is kept. Registers must be written over APB only while idle; not enforced.
`default_nettype none
module arp_responder_with_peer_learning_core #(
    parameter int FRAME_MAX = arpr_pkg::FRAME_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_end,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_kind,
    output logic [7:0]       o_tx_byte,
    output logic             o_tx_last,
    output logic [47:0]      o_peer_mac,
    output logic             o_peer_mac_valid
);

    localparam int CW = $clog2(FRAME_MAX + 1);
    localparam int AW = $clog2(FRAME_MAX);
    localparam int JW = CW + $bits(arpr_pkg::t_job);

    localparam logic [1:0] REG_OWN_IP  = 2'd0;
    localparam logic [1:0] REG_PEER_IP = 2'd1;
    localparam logic [1:0] REG_OWN_MAC = 2'd2;

    arpr_pkg::t_cfg r_cfg;
    logic           wr;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata;

    logic                f_job_push, q_full, q_empty, b_pop, reply_done;
    arpr_pkg::t_job      f_job, b_job;
    logic [CW-1:0]       f_len, b_len;
    logic [JW-1:0]       q_out;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            unique case (paddr[4:3])
                REG_OWN_IP:  r_cfg.own_ip  <= pwdata[31:0];
                REG_PEER_IP: r_cfg.peer_ip <= pwdata[31:0];
                REG_OWN_MAC: r_cfg.own_mac <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_OWN_IP:  prdata = {32'h0, r_cfg.own_ip};
            REG_PEER_IP: prdata = {32'h0, r_cfg.peer_ip};
            REG_OWN_MAC: prdata = {16'h0, r_cfg.own_mac};
            default:     prdata = '0;
        endcase
    end

    arpr_front #(.FRAME_MAX(FRAME_MAX)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .i_frame_end  (i_frame_end),
        .i_cfg        (r_cfg),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_job_push   (f_job_push),
        .o_job        (f_job),
        .o_job_len    (f_len),
        .i_job_full   (q_full),
        .i_reply_done (reply_done)
    );

    arpr_ram #(.WIDTH(8), .DEPTH(FRAME_MAX)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    arpr_jobq #(.W(JW)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_job_push),
        .i_data  ({f_len, f_job}),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    assign b_len = q_out[JW-1 -: CW];
    assign b_job = arpr_pkg::t_job'(q_out[$bits(arpr_pkg::t_job)-1:0]);

    arpr_back #(.FRAME_MAX(FRAME_MAX)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_job_empty      (q_empty),
        .i_job            (b_job),
        .i_job_len        (b_len),
        .o_job_pop        (b_pop),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata),
        .o_reply_done     (reply_done),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_kind           (o_kind),
        .o_tx_byte        (o_tx_byte),
        .o_tx_last        (o_tx_last),
        .o_peer_mac       (o_peer_mac),
        .o_peer_mac_valid (o_peer_mac_valid)
    );

endmodule
`default_nettype wire
